/* hw/rtl/fractal_escape_time_unit_assert.svh */
// Assertion macros for the escape-time unit.
// Each macro expects signals clk and arst_n in the using module.
`ifndef FRACTAL_ESCAPE_TIME_UNIT_ASSERT_SVH
`define FRACTAL_ESCAPE_TIME_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fet_pkg.sv */
// Shared constants and helpers for the escape-time unit.
// No dependencies.
package fet_pkg;

	localparam int unsigned FRAC_BITS = 26;

	// |z|^2 threshold of 4.0 in Q12.52
	localparam logic [63:0] ESCAPE_SQ = 64'd1 << (2 * FRAC_BITS + 2);

	// Configuration register indexes
	localparam logic [2:0] REG_JULIA_MODE = 3'd0;
	localparam logic [2:0] REG_ITER_LIMIT = 3'd1;
	localparam logic [2:0] REG_X_ORIGIN   = 3'd2;
	localparam logic [2:0] REG_Y_ORIGIN   = 3'd3;
	localparam logic [2:0] REG_SPACING    = 3'd4;
	localparam logic [2:0] REG_JC_REAL    = 3'd5;
	localparam logic [2:0] REG_JC_IMAG    = 3'd6;

	typedef logic signed [44:0] wide_t;
	typedef logic signed [31:0] fix_t;

	// Clamp a wide signed value to the signed 32-bit range
	function automatic fix_t sat32(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = 45'sd2147483647;
		lo = -45'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return -32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

/* hw/rtl/fractal_escape_time_unit.sv */
// Escape-time iteration unit for Mandelbrot and Julia sets (Q6.26 fixed point).
// Depends on fet_pkg and fractal_escape_time_unit_assert.svh.
//
// Usage:
//   Input stream s_axis_*: one pixel per transaction, column and row indexes.
//   Output stream m_axis_*: one escape count (steps modulo 256) per pixel.
//   Config channel cfg_*: register writes, always ready; write only while idle.
// Sequencing:
//   All multiplies go through one registered 32x32 signed multiplier.
//   Point setup runs through states PX, PY and INIT; every z = z*z + c step
//   runs through SQR, SQI, CHK and UPD (zr*zr, zi*zi, zr*zi with escape
//   check, update), and the final check through SQR, SQI and CHK.
//   Input is taken only in idle: no new pixel until the last one is finished.
// Output:
//   A finished count sits in an output register; the next pixel may be
//   accepted while it waits. If that pixel finishes before the count is
//   taken, the unit holds until the output register frees up.
// Reset:
//   arst_n clears the sequencer and output valid and returns all
//   configuration registers to their defaults (Mandelbrot, limit 255).
`include "fractal_escape_time_unit_assert.svh"

module fractal_escape_time_unit
	import fet_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [11:0] column, [23:12] row
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] escape_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [16:0] COL_LIM = 17'(MAX_WIDTH - 1);
	localparam logic [16:0] ROW_LIM = 17'(MAX_HEIGHT - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PX   = 4'd1;
	localparam logic [3:0] ST_PY   = 4'd2;
	localparam logic [3:0] ST_INIT = 4'd3;
	localparam logic [3:0] ST_SQR  = 4'd4;
	localparam logic [3:0] ST_SQI  = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	// Configuration
	logic        julia_mode_q;
	logic [15:0] iteration_limit_q;
	fix_t        x_origin_q;
	fix_t        y_origin_q;
	logic [30:0] pixel_spacing_q;
	fix_t        julia_c_real_q;
	fix_t        julia_c_imag_q;

	// Sequencer and datapath
	logic [3:0]         state_q;
	logic [11:0]        col_q;
	logic [11:0]        row_q;
	fix_t               px_q;
	fix_t               zr_q;
	fix_t               zi_q;
	fix_t               cr_q;
	fix_t               ci_q;
	logic [15:0]        steps_q;
	logic signed [63:0] mul_q;
	logic signed [63:0] sqr_q;
	logic signed [63:0] sqi_q;
	logic               m_valid_q;
	logic [7:0]         m_data_q;

	fix_t               mul_a;
	fix_t               mul_b;
	logic signed [63:0] mul_prod;
	logic [16:0]        col_ext;
	logic [16:0]        row_ext;
	logic [11:0]        col_clamp;
	logic [11:0]        row_clamp;
	wide_t              coord_sum;
	fix_t               coord_sat;
	logic [63:0]        mag_sum;
	logic               iter_done;
	logic signed [63:0] diff;
	logic signed [63:0] diff_sh;
	logic signed [63:0] prod_sh;
	fix_t               zr_next;
	fix_t               zi_next;
	logic               out_free;
	logic               in_take;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Clamp indexes past the image edge
	always_comb begin
		col_ext   = {5'd0, s_axis_tdata[11:0]};
		row_ext   = {5'd0, s_axis_tdata[23:12]};
		col_clamp = (col_ext > COL_LIM) ? COL_LIM[11:0] : col_ext[11:0];
		row_clamp = (row_ext > ROW_LIM) ? ROW_LIM[11:0] : row_ext[11:0];
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PX: begin
				mul_a = {20'd0, col_q};
				mul_b = {1'b0, pixel_spacing_q};
			end
			ST_PY: begin
				mul_a = {20'd0, row_q};
				mul_b = {1'b0, pixel_spacing_q};
			end
			ST_SQR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_SQI: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_CHK: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;

	// Origin plus index times spacing: product is below 2^43
	always_comb begin
		if (state_q == ST_PY) begin
			coord_sum = {{13{x_origin_q[31]}}, x_origin_q} + $signed(mul_q[44:0]);
		end else begin
			coord_sum = {{13{y_origin_q[31]}}, y_origin_q} + $signed(mul_q[44:0]);
		end
		coord_sat = sat32(coord_sum);
	end

	// Escape test: sqr_q holds zr^2, mul_q holds zi^2 during the check
	always_comb begin
		mag_sum   = sqr_q + mul_q;
		iter_done = (steps_q >= iteration_limit_q) || (mag_sum >= ESCAPE_SQ);
	end

	// Step update: floor shifts are arithmetic shifts
	always_comb begin
		diff    = sqr_q - sqi_q;
		diff_sh = diff >>> FRAC_BITS;
		prod_sh = mul_q >>> (FRAC_BITS - 1);
		zr_next = sat32($signed(diff_sh[44:0]) + {{13{cr_q[31]}}, cr_q});
		zi_next = sat32($signed(prod_sh[44:0]) + {{13{ci_q[31]}}, ci_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_mode_q      <= 1'b0;
			iteration_limit_q <= 16'd255;
			x_origin_q        <= '0;
			y_origin_q        <= '0;
			pixel_spacing_q   <= 31'd67108;
			julia_c_real_q    <= '0;
			julia_c_imag_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_JULIA_MODE: julia_mode_q      <= cfg_data[0];
				REG_ITER_LIMIT: iteration_limit_q <= cfg_data[15:0];
				REG_X_ORIGIN:   x_origin_q        <= cfg_data;
				REG_Y_ORIGIN:   y_origin_q        <= cfg_data;
				REG_SPACING:    pixel_spacing_q   <= cfg_data[30:0];
				REG_JC_REAL:    julia_c_real_q    <= cfg_data;
				REG_JC_IMAG:    julia_c_imag_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// load a finished count, else drop valid once taken
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_PX;
					end
				end
				ST_PX:   state_q <= ST_PY;
				ST_PY:   state_q <= ST_INIT;
				ST_INIT: state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_SQI;
				ST_SQI:  state_q <= ST_CHK;
				ST_CHK:  state_q <= iter_done ? ST_OUT : ST_UPD;
				ST_UPD:  state_q <= ST_SQR;
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_prod;
		if (in_take) begin
			col_q   <= col_clamp;
			row_q   <= row_clamp;
			steps_q <= '0;
		end
		if (state_q == ST_PY) begin
			px_q <= coord_sat;
		end
		if (state_q == ST_INIT) begin
			if (julia_mode_q) begin
				zr_q <= px_q;
				zi_q <= coord_sat;
				cr_q <= julia_c_real_q;
				ci_q <= julia_c_imag_q;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= px_q;
				ci_q <= coord_sat;
			end
		end
		if (state_q == ST_SQI) begin
			sqr_q <= mul_q;
		end
		if (state_q == ST_CHK) begin
			sqi_q <= mul_q;
		end
		if (state_q == ST_UPD) begin
			zr_q    <= zr_next;
			zi_q    <= zi_next;
			steps_q <= steps_q + 16'd1;
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= steps_q[7:0];
		end
	end

	`FET_ASSERT_NOW(a_step_within_limit, state_q == ST_UPD, steps_q < iteration_limit_q, "step beyond iteration limit")
	`FET_ASSERT_NEXT(a_accept_starts, in_take, state_q == ST_PX, "accepted pixel did not start setup")
	`FET_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free, m_axis_tvalid && (m_axis_tdata == $past(steps_q[7:0])), "escape count not loaded")
	`FET_ASSERT_NEXT(a_upd_after_chk, (state_q == ST_CHK) && !iter_done, state_q == ST_UPD, "update did not follow a passing check")

endmodule

/* tb/sv/fractal_escape_time_unit_tb.sv */
// Self-checking testbench for the escape-time unit: drives pixels and register
// writes, predicts each escape count and compares it with the output stream.
// Depends on fet_pkg and the fractal_escape_time_unit RTL.
module fractal_escape_time_unit_tb
	import fet_pkg::*;
;

	localparam int unsigned IMG_WIDTH      = 4096;
	localparam int unsigned IMG_HEIGHT     = 4096;
	localparam int unsigned Q_SHIFT        = 26;
	localparam longint unsigned FOUR_Q52   = 64'd1 << 54;
	localparam logic [2:0]  REG_SPARE      = 3'd7;	// decodes to no register
	localparam int          RANDOM_PIXELS  = 1800;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam fix_t        ONE            = 32'sd67108864;

	typedef struct {
		logic        julia;
		logic [15:0] limit;
		fix_t        x0;
		fix_t        y0;
		logic [30:0] spacing;
		fix_t        cr;
		fix_t        ci;
	} view_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  count;
	} pixel_count_t;

	class escape_count_board;
		view_t        view;
		pixel_count_t pending_counts[$];
		int           errors;

		function new();
			view = '{julia: 1'b0, limit: 16'd255, x0: 0, y0: 0, spacing: 31'd67108,
				cr: 0, ci: 0};
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_JULIA_MODE: view.julia = data[0];
				REG_ITER_LIMIT: view.limit = data[15:0];
				REG_X_ORIGIN: view.x0 = data;
				REG_Y_ORIGIN: view.y0 = data;
				REG_SPACING: view.spacing = data[30:0];
				REG_JC_REAL: view.cr = data;
				REG_JC_IMAG: view.ci = data;
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function logic [7:0] predict_escape_count(logic [11:0] col, logic [11:0] row);
			longint unsigned c, r, mag;
			longint px, py, zr, zi, kr, ki, d, p;
			int unsigned steps;
			c = col;
			r = row;
			if (c >= IMG_WIDTH)
				c = IMG_WIDTH - 1;
			if (r >= IMG_HEIGHT)
				r = IMG_HEIGHT - 1;
			px = clamp32(longint'(view.x0) + longint'(c) * longint'(view.spacing));
			py = clamp32(longint'(view.y0) + longint'(r) * longint'(view.spacing));
			if (view.julia) begin
				zr = px;
				zi = py;
				kr = longint'(view.cr);
				ki = longint'(view.ci);
			end else begin
				zr = 0;
				zi = 0;
				kr = px;
				ki = py;
			end
			steps = 0;
			forever begin
				mag = longint'(zr * zr) + longint'(zi * zi);
				if (steps >= view.limit || mag >= FOUR_Q52)
					break;
				d = zr * zr - zi * zi;
				p = zr * zi;
				zr = clamp32((d >>> Q_SHIFT) + kr);
				zi = clamp32((p >>> (Q_SHIFT - 1)) + ki);
				steps++;
			end
			return steps[7:0];
		endfunction

		function void note_pixel(logic [11:0] col, logic [11:0] row);
			pixel_count_t e;
			e.col = col;
			e.row = row;
			e.count = predict_escape_count(col, row);
			pending_counts.push_back(e);
		endfunction

		function int pending();
			return pending_counts.size();
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_count(logic [7:0] got);
			pixel_count_t e;
			if (pending_counts.size() == 0) begin
				report($sformatf("escape_count %0d with no pixel outstanding", got));
			end else begin
				e = pending_counts.pop_front();
				if (got !== e.count)
					report($sformatf("pixel (%0d,%0d): escape_count %0d, expected %0d",
						e.col, e.row, got, e.count));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;	// [11:0] column, [23:12] row
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;	// [7:0] escape_count
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int quiet_cycles = 0;

	escape_count_board sb = new();

	fractal_escape_time_unit #(
		.MAX_WIDTH(IMG_WIDTH),
		.MAX_HEIGHT(IMG_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_count(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("** fractal_escape_time_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic view_t make_view(logic julia, logic [15:0] limit, fix_t x0, fix_t y0,
			logic [30:0] spacing, fix_t cr, fix_t ci);
		view_t v;
		v = '{julia: julia, limit: limit, x0: x0, y0: y0, spacing: spacing, cr: cr, ci: ci};
		return v;
	endfunction

	function automatic fix_t near_unit();
		return fix_t'(int'($urandom_range(0, 2 * ONE)) - ONE);
	endfunction

	function automatic view_t random_view();
		view_t v;
		int roll;
		roll = $urandom_range(99);
		v.julia = (roll < 40) ? 1'b0 : (roll < 70) ? 1'b1 : 1'(($urandom_range(1)));
		if (v.julia) begin
			v.x0 = -(ONE + ONE / 2) + fix_t'($urandom_range(0, ONE / 4));
			v.y0 = -(ONE + ONE / 4) + fix_t'($urandom_range(0, ONE / 4));
		end else begin
			v.x0 = -(2 * ONE) + fix_t'($urandom_range(0, ONE / 2));
			v.y0 = -(ONE + ONE / 4) + fix_t'($urandom_range(0, ONE / 4));
		end
		v.spacing = 31'($urandom_range(2000, 50000));
		v.cr = near_unit();
		v.ci = near_unit();
		v.limit = 16'($urandom_range(1, 64));
		if (roll >= 70 && roll < 80) begin
			v.limit = 16'($urandom_range(65, 300));
		end else if (roll >= 80 && roll < 85) begin
			v.limit = '0;
			v.x0 = $urandom;
			v.spacing = 31'($urandom);
		end else if (roll >= 85 && roll < 92) begin
			// keep every point at |z| >= 4 so a huge limit stays cheap
			v.limit = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom_range(301, 65535));
			v.x0 = 4 * ONE + fix_t'($urandom_range(0, 4 * ONE));
			v.y0 = $urandom;
			v.spacing = 31'($urandom_range(1, 1 << 20));
		end else if (roll >= 92) begin
			v.limit = 16'($urandom_range(1, 300));
			v.x0 = $urandom;
			v.y0 = $urandom;
			v.spacing = 31'($urandom);
			v.cr = $urandom;
			v.ci = $urandom;
		end
		return v;
	endfunction

	task automatic wait_for_counts();
		if (sb.pending() != 0) begin
			s_axis_tvalid <= 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
		end
	endtask

	task automatic load_view(view_t v);
		logic [31:0] vals [8];
		wait_for_counts();
		vals[REG_JULIA_MODE] = 32'(v.julia);
		vals[REG_ITER_LIMIT] = {16'($urandom_range(65535)), v.limit};
		vals[REG_X_ORIGIN] = v.x0;
		vals[REG_Y_ORIGIN] = v.y0;
		vals[REG_SPACING] = {1'($urandom_range(1)), v.spacing};
		vals[REG_JC_REAL] = v.cr;
		vals[REG_JC_IMAG] = v.ci;
		vals[REG_SPARE] = $urandom;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(3'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [11:0] col, logic [11:0] row);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row, col};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(col, row);
	endtask

	initial begin
		view_t v;
		int sent;
		int phase;
		int batch;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: origin is inside the set, far corner escapes at once
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd2048, 12'd1000);

		// zero limit yields a zero count
		load_view(make_view(1'b1, 16'd0, -ONE, -ONE, 31'd30000, ONE / 3, ONE / 5));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd2222);

		// count past 255 wraps
		load_view(make_view(1'b0, 16'd300, -(ONE / 2), 0, 31'd1, 0, 0));
		send_pixel(12'd0, 12'd0);

		// zero spacing maps every pixel to the origin
		load_view(make_view(1'b0, 16'd255, ONE / 4 + ONE / 16, ONE / 2, 31'd0, 0, 0));
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);

		// saturated coordinates
		load_view(make_view(1'b0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF,
			0, 0));
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd0, 12'd0);
		load_view(make_view(1'b1, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF));
		send_pixel(12'd2048, 12'd2048);
		load_view(make_view(1'b1, 16'hFFFF, 0, 0, 31'd1, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send_pixel(12'd3, 12'd5);

		// a familiar Julia set
		load_view(make_view(1'b1, 16'd255, -(ONE + ONE / 2), -ONE, 31'd47000,
			-fix_t'(53687091), 32'sd10468982));
		send_pixel(12'd2048, 12'd1430);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1365, 12'd2730);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			v = random_view();
			load_view(v);
			case (phase % 4)
				0: begin send_idle_pct = 0; ready_stall_pct = 0; end
				1: begin send_idle_pct = 56; ready_stall_pct = 0; end
				2: begin send_idle_pct = 0; ready_stall_pct = 56; end
				default: begin send_idle_pct = 37; ready_stall_pct = 37; end
			endcase
			batch = (v.limit > 64 && v.limit != 16'hFFFF) ? 30 : 100;
			repeat (batch) begin
				// now and then hold off until the unit has drained
				if ($urandom_range(63) == 0)
					wait_for_counts();
				send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
				sent++;
			end
			phase++;
		end

		wait_for_counts();
		s_axis_tvalid <= 1'b0;
		repeat (64) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d escape counts never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("** fractal_escape_time_unit: PASSED **");
		end else begin
			$display("** fractal_escape_time_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fet_pkg.sv
hw/rtl/fractal_escape_time_unit.sv
tb/sv/fractal_escape_time_unit_tb.sv
